[rtl/core/lcgx_pkg.sv]
// Package for the LCG keystream XOR cipher: word types, register map,
// state encodings and keystream helpers.
// No dependencies; imported by lcgx_succ, the cipher top and the tb.
package lcgx_pkg;

    localparam int WORD_W = 31;
    localparam int PROD_W = 2 * WORD_W;
    localparam int CNT_W  = 6;

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(WORD_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

    localparam int ADDR_W = 4;

    localparam logic [1:0] REG_SEED       = 2'd0;
    localparam logic [1:0] REG_MULTIPLIER = 2'd1;
    localparam logic [1:0] REG_INCREMENT  = 2'd2;
    localparam logic [1:0] REG_MODULUS    = 2'd3;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
        logic       last;
    } lcgx_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_out;
    } lcgx_out_t;

    typedef struct packed {
        logic  start;
        word_t word;
        word_t mult;
        word_t incr;
        word_t modulus;
    } lcgx_succ_req_t;

    typedef struct packed {
        logic  done;
        word_t word;
    } lcgx_succ_rsp_t;

    typedef enum logic [1:0] {
        SU_IDLE,
        SU_MUL,
        SU_DIV
    } lcgx_succ_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_FILL,
        ST_NEXT,
        ST_EMIT
    } lcgx_state_t;

    function automatic logic [7:0] key_byte(input word_t w, input logic [1:0] pos);
        logic [31:0] shifted;
        shifted = {1'b0, w} >> {pos, 3'b000};
        return shifted[7:0];
    endfunction

endpackage

[rtl/core/lcgx_succ.sv]
// Successor unit: (mult * word + incr) mod modulus, bit-serial.
// Shift-add multiply (one bit per cycle, increment folded in serially),
// then restoring remainder over the 62-bit product. Uses lcgx_pkg.
module lcgx_succ
    import lcgx_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  lcgx_succ_req_t req,
    output lcgx_succ_rsp_t rsp
);

    lcgx_succ_state_t   state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    word_t              w_reg, w_next;
    word_t              inc_reg, inc_next;
    word_t              mod_reg, mod_next;
    logic [WORD_W:0]    hi_reg, hi_next;
    word_t              lo_reg, lo_next;
    word_t              rem_reg, rem_next;
    logic               done_reg, done_next;

    logic [WORD_W+1:0]  mul_sum;
    word_t              addend;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  prod_shl;
    logic [WORD_W:0]    trial;
    logic [WORD_W:0]    trial_sub;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SU_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
        w_reg   <= w_next;
        inc_reg <= inc_next;
        mod_reg <= mod_next;
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        rem_reg <= rem_next;
    end

    always_comb begin
        addend    = lo_reg[0] ? w_reg : '0;
        mul_sum   = {1'b0, hi_reg} + {2'b00, addend} + {{(WORD_W+1){1'b0}}, inc_reg[0]};
        prod      = {hi_reg[WORD_W-1:0], lo_reg};
        prod_shl  = {prod[PROD_W-2:0], 1'b0};
        trial     = {rem_reg, prod[PROD_W-1]};
        trial_sub = trial - {1'b0, mod_reg};

        state_next = state_reg;
        cnt_next   = cnt_reg;
        w_next     = w_reg;
        inc_next   = inc_reg;
        mod_next   = mod_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        rem_next   = rem_reg;
        done_next  = 1'b0;

        unique case (state_reg)
            SU_IDLE: begin
                if (req.start) begin
                    w_next     = req.word;
                    inc_next   = req.incr;
                    mod_next   = (req.modulus == '0) ? WORD_W'(1) : req.modulus;
                    hi_next    = '0;
                    lo_next    = req.mult;
                    cnt_next   = '0;
                    state_next = SU_MUL;
                end
            end
            SU_MUL: begin
                hi_next  = mul_sum[WORD_W+1:1];
                lo_next  = {mul_sum[0], lo_reg[WORD_W-1:1]};
                inc_next = {1'b0, inc_reg[WORD_W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST) begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    state_next = SU_DIV;
                end
            end
            SU_DIV: begin
                hi_next  = {1'b0, prod_shl[PROD_W-1:WORD_W]};
                lo_next  = prod_shl[WORD_W-1:0];
                rem_next = (trial >= {1'b0, mod_reg}) ? trial_sub[WORD_W-1:0]
                                                      : trial[WORD_W-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    cnt_next   = '0;
                    done_next  = 1'b1;
                    state_next = SU_IDLE;
                end
            end
            default: begin
                state_next = SU_IDLE;
            end
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.word = rem_reg;

endmodule

[rtl/core/lcg_keystream_xor_cipher.sv]
// Top level of the LCG keystream XOR cipher: APB register file, byte
// sequencer and output register. Uses lcgx_pkg and lcgx_succ.
//
//   channel   direction  handshake                 word
//   s_        in         s_valid / s_ready         lcgx_in_t  (data_byte, start_req, last)
//   m_        out        m_valid / m_ready         lcgx_out_t (out_byte, last_out)
//   apb       in         psel/penable/pwrite       seed, multiplier, increment, modulus
//
// One byte is taken at a time. A byte inside a keystream word passes from
// ST_IDLE through ST_EMIT to the output register. A byte that starts a
// message or crosses a word boundary waits for one successor word from
// lcgx_succ (serial multiply, then remainder, then handoff); the first
// boundary after reset without a start takes two successors.
// Reset is synchronous on aresetn; a stalled m_ready holds the result in the
// output register while the next byte is accepted.
module lcg_keystream_xor_cipher
    import lcgx_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  lcgx_in_t          s_data,

    output logic              m_valid,
    input  logic              m_ready,
    output lcgx_out_t         m_data,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    lcgx_state_t    state_reg, state_next;
    word_t          seed_reg, mult_reg, incr_reg, mod_reg;
    word_t          cur_reg, cur_next;
    word_t          nxt_reg, nxt_next;
    logic           nrdy_reg, nrdy_next;
    logic [1:0]     pos_reg, pos_next;
    logic [7:0]     res_reg, res_next;
    logic           lastp_reg, lastp_next;
    logic           m_valid_reg, m_valid_next;
    lcgx_out_t      m_data_reg, m_data_next;

    lcgx_succ_req_t succ_req;
    lcgx_succ_rsp_t succ_rsp;
    logic           cfg_wr;

    lcgx_succ u_succ (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (succ_req),
        .rsp     (succ_rsp)
    );

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
            mult_reg <= '0;
            incr_reg <= '0;
            mod_reg  <= WORD_W'(1);
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_SEED:       seed_reg <= pwdata[WORD_W-1:0];
                REG_MULTIPLIER: mult_reg <= pwdata[WORD_W-1:0];
                REG_INCREMENT:  incr_reg <= pwdata[WORD_W-1:0];
                REG_MODULUS:    mod_reg  <= pwdata[WORD_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SEED:       prdata = {1'b0, seed_reg};
            REG_MULTIPLIER: prdata = {1'b0, mult_reg};
            REG_INCREMENT:  prdata = {1'b0, incr_reg};
            REG_MODULUS:    prdata = {1'b0, mod_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cur_reg     <= '0;
            nxt_reg     <= '0;
            nrdy_reg    <= 1'b0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            nxt_reg     <= nxt_next;
            nrdy_reg    <= nrdy_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
        res_reg    <= res_next;
        lastp_reg  <= lastp_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        nxt_next     = nxt_reg;
        nrdy_next    = nrdy_reg;
        pos_next     = pos_reg;
        res_next     = res_reg;
        lastp_next   = lastp_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        succ_req.start   = 1'b0;
        succ_req.word    = cur_reg;
        succ_req.mult    = mult_reg;
        succ_req.incr    = incr_reg;
        succ_req.modulus = mod_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    lastp_next = s_data.last;
                    if (s_data.start_req) begin
                        cur_next       = seed_reg;
                        pos_next       = 2'd1;
                        res_next       = s_data.data_byte ^ seed_reg[7:0];
                        succ_req.start = 1'b1;
                        succ_req.word  = seed_reg;
                        state_next     = ST_START;
                    end else begin
                        res_next = s_data.data_byte ^ key_byte(cur_reg, pos_reg);
                        pos_next = pos_reg + 2'd1;
                        if (pos_reg == 2'd3) begin
                            succ_req.start = 1'b1;
                            if (nrdy_reg) begin
                                cur_next      = nxt_reg;
                                succ_req.word = nxt_reg;
                                state_next    = ST_NEXT;
                            end else begin
                                state_next    = ST_FILL;
                            end
                        end else begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_START, ST_NEXT: begin
                if (succ_rsp.done) begin
                    nxt_next   = succ_rsp.word;
                    nrdy_next  = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_FILL: begin
                if (succ_rsp.done) begin
                    cur_next       = succ_rsp.word;
                    succ_req.start = 1'b1;
                    succ_req.word  = succ_rsp.word;
                    state_next     = ST_NEXT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next         = 1'b1;
                    m_data_next.out_byte = res_reg;
                    m_data_next.last_out = lastp_reg;
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[tb/lcgx_cipher_check.sv]
// Checker for the LCG keystream XOR cipher: tracks the register writes on the
// APB port, predicts every ciphertext word and compares it with the m_ channel.
// Depends on lcgx_pkg for the word types and the register map.
`timescale 1ns / 1ps

module lcgx_cipher_check
    import lcgx_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    input  logic              s_ready,
    input  lcgx_in_t          s_data,

    input  logic              m_valid,
    input  logic              m_ready,
    input  lcgx_out_t         m_data,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,

    output int                fail_count,
    output int                pending,
    output int                checked
);

    word_t      seed_r;
    word_t      mult_r;
    word_t      incr_r;
    word_t      mod_r;

    word_t      ks_word;
    word_t      ks_next;
    logic [1:0] ks_pos;
    logic       ks_next_ok;

    lcgx_out_t  cipher_q [$];

    function automatic word_t lcg_next(input word_t w);
        logic [63:0] m;
        logic [63:0] v;
        m = {33'd0, mod_r};
        if (m == 64'd0) m = 64'd1;
        v = {33'd0, mult_r} * {33'd0, w} + {33'd0, incr_r};
        return word_t'(v % m);
    endfunction

    task automatic load_keyword(input word_t w);
        ks_word    = w;
        ks_next    = lcg_next(w);
        ks_next_ok = 1'b1;
    endtask

    task automatic encipher(input lcgx_in_t w);
        lcgx_out_t   r;
        logic [31:0] kw;
        if (w.start_req) begin
            ks_pos = 2'd0;
            load_keyword(seed_r);
        end
        kw         = {1'b0, ks_word};
        r.out_byte = w.data_byte ^ kw[8*ks_pos +: 8];
        r.last_out = w.last;
        ks_pos     = ks_pos + 2'd1;
        if (ks_pos == 2'd0) load_keyword(ks_next_ok ? ks_next : lcg_next(ks_word));
        cipher_q.insert(cipher_q.size(), r);
    endtask

    task automatic compare(input lcgx_out_t got);
        lcgx_out_t want;
        if (cipher_q.size() == 0) begin
            $error("unexpected word: out_byte %h last_out %b", got.out_byte, got.last_out);
            fail_count++;
        end else begin
            want = cipher_q.pop_front();
            checked++;
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
                fail_count++;
            end
            if (got.last_out !== want.last_out) begin
                $error("last_out: expected %b, actual %b", want.last_out, got.last_out);
                fail_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            seed_r     = '0;
            mult_r     = '0;
            incr_r     = '0;
            mod_r      = word_t'(1);
            ks_word    = '0;
            ks_next    = '0;
            ks_pos     = 2'd0;
            ks_next_ok = 1'b0;
            fail_count = 0;
            checked    = 0;
            cipher_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_SEED:       seed_r = pwdata[WORD_W-1:0];
                    REG_MULTIPLIER: mult_r = pwdata[WORD_W-1:0];
                    REG_INCREMENT:  incr_r = pwdata[WORD_W-1:0];
                    REG_MODULUS:    mod_r  = pwdata[WORD_W-1:0];
                endcase
            end
            if (s_valid && s_ready) encipher(s_data);
            if (m_valid && m_ready) compare(m_data);
        end
        pending = cipher_q.size();
    end

endmodule

[tb/tb.sv]
// Testbench top for the LCG keystream XOR cipher: clock, reset, APB register
// setup, byte stimulus with random idling and the verdict.
// Depends on lcgx_pkg, lcg_keystream_xor_cipher and lcgx_cipher_check.
`timescale 1ns / 1ps

module tb;
    import lcgx_pkg::*;

    localparam int SETTLE = 250;

    logic              aclk;
    logic              aresetn = 1'b0;

    logic              s_valid = 1'b0;
    logic              s_ready;
    lcgx_in_t          s_data  = '0;

    logic              m_valid;
    logic              m_ready = 1'b0;
    lcgx_out_t         m_data;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    int                fail_count;
    int                pending;
    int                checked;

    logic              src_steady  = 1'b0;
    logic              sink_steady = 1'b0;
    int                bytes_sent  = 0;
    int                messages    = 0;
    int                settings    = 0;

    lcg_keystream_xor_cipher dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lcgx_cipher_check check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #15_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin : sink
        int gap;
        forever begin
            gap = sink_steady ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'($urandom_range(1, 300));
            default: return $urandom;
        endcase
    endfunction

    task automatic set_regs(input logic [3:0] mask, input logic [31:0] s, a, c, m);
        logic [31:0] val [4];
        val[REG_SEED]       = s;
        val[REG_MULTIPLIER] = a;
        val[REG_INCREMENT]  = c;
        val[REG_MODULUS]    = m;
        for (int i = 0; i < 4; i++) begin
            if (mask[i]) begin
                psel    <= 1'b1;
                penable <= 1'b0;
                pwrite  <= 1'b1;
                paddr   <= {2'(i), 2'b00};
                pwdata  <= val[i];
                @(posedge aclk);
                penable <= 1'b1;
                do @(posedge aclk); while (!pready);
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        settings++;
    endtask

    task automatic send_word(input logic [7:0] d, input logic st, input logic lst);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= {d, st, lst};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
        bytes_sent++;
    endtask

    task automatic send_msg(input int len);
        for (int i = 0; i < len; i++) send_word(8'($urandom), i == 0, i == len - 1);
        messages++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin : stimulus
        int          phase_len;
        int          kind;
        int          n;
        logic [3:0]  mask;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // run from the reset word without a start, across a word boundary
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'hA5, 1'b0, 1'b0);
        send_word(8'h5A, 1'b0, 1'b1);
        send_word(8'h01, 1'b0, 1'b0);
        drain();

        set_regs(4'b1111, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h80, 1'b0, 1'b1);
        send_msg(6);
        send_msg(1);
        drain();

        // zero modulus
        set_regs(4'b1110, 32'd0, $urandom, $urandom, 32'd0);
        send_msg(5);
        drain();

        // seed above modulus
        set_regs(4'b1111, 32'd1000, 32'd3, 32'd2, 32'd7);
        send_msg(5);
        drain();

        while (bytes_sent < 1025) begin
            mask = 4'($urandom);
            if (mask == 4'd0) mask = 4'b1111;
            set_regs(mask, pick_value(), pick_value(), pick_value(), pick_value());
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            phase_len   = bytes_sent + $urandom_range(60, 100);
            while (bytes_sent < phase_len) begin
                kind = $urandom_range(0, 9);
                if (kind == 0) begin
                    n = $urandom_range(1, 6);
                    repeat (n) send_word(8'($urandom), $urandom_range(0, 7) == 0,
                                         $urandom_range(0, 3) == 0);
                end else if (kind == 1) begin
                    n = $urandom_range(1, 10);
                    for (int i = 0; i < n; i++) send_word(8'($urandom), i == 0, 1'b0);
                end else begin
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48)
                                                    : $urandom_range(1, 16);
                    send_msg(n);
                end
            end
            drain();
        end

        $display("Ran %0d bytes (%0d whole messages) under %0d register settings; %0d words checked.",
                 bytes_sent, messages, settings, checked);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[lcg_keystream_xor_cipher.f]
rtl/core/lcgx_pkg.sv
rtl/core/lcgx_succ.sv
rtl/core/lcg_keystream_xor_cipher.sv
tb/lcgx_cipher_check.sv
tb/tb.sv
